/* rtl/cubic_hermite_point_assert.svh */
// assertion macros shared by the cubic hermite point modules
`ifndef CUBIC_HERMITE_POINT_ASSERT_SVH
`define CUBIC_HERMITE_POINT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHP_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHP_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/chp_pkg.sv */
// shared types, widths and constants of the cubic hermite point block
package chp_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int PARAM_FRAC  = 16;
    localparam int PARAM_WIDTH = PARAM_FRAC + 2;
    localparam int T_W         = PARAM_FRAC + 1;
    localparam int TSQ_W       = 2 * T_W;
    localparam int WEIGHT_W    = PARAM_FRAC + 3;
    localparam int PROD_W      = COORD_WIDTH + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int RES_W       = SUM_W - PARAM_FRAC;
    localparam int Q_DEPTH     = 8;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PARAM_WIDTH-1:0] param_t;
    typedef logic        [T_W-1:0]         tparam_t;
    typedef logic        [TSQ_W-1:0]       tsq_t;
    typedef logic signed [WEIGHT_W-1:0]    weight_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [RES_W-1:0]       res_t;
    typedef logic        [Q_AW-1:0]        qptr_t;
    typedef logic        [Q_AW:0]          qlevel_t;

    localparam tparam_t T_ONE      = tparam_t'(2 ** PARAM_FRAC);
    localparam tsq_t    T_HALF     = tsq_t'(2 ** (PARAM_FRAC - 1));
    localparam weight_t WEIGHT_ONE = weight_t'(2 ** PARAM_FRAC);
    localparam sum_t    SUM_HALF   = sum_t'(2 ** (PARAM_FRAC - 1));
    localparam coord_t  COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t  COORD_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_tan_x;
        coord_t start_tan_y;
        coord_t end_x;
        coord_t end_y;
        coord_t end_tan_x;
        coord_t end_tan_y;
    } coords_t;

    // one classified job: the coordinates and the four basis weights
    typedef struct packed {
        coords_t c;
        weight_t h1;
        weight_t h2;
        weight_t h3;
        weight_t h4;
    } job_t;

    // queue status seen by the front and the back
    typedef struct packed {
        qlevel_t level;
        logic    empty;
    } qstat_t;

    // zero-extend a parameter power into the signed weight width
    function automatic weight_t to_weight(input tparam_t v);
        return signed'({{(WEIGHT_W-T_W){1'b0}}, v});
    endfunction

endpackage

/* rtl/chp_if.sv */
// handshake channels of the cubic hermite point block
interface chp_item_if;
    import chp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t start_tan_x;
    coord_t start_tan_y;
    coord_t end_x;
    coord_t end_y;
    coord_t end_tan_x;
    coord_t end_tan_y;
    param_t interp_param;

    modport source (
        output valid, start_x, start_y, start_tan_x, start_tan_y,
               end_x, end_y, end_tan_x, end_tan_y, interp_param,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_tan_x, start_tan_y,
               end_x, end_y, end_tan_x, end_tan_y, interp_param,
        output ready
    );
endinterface

interface chp_result_if;
    import chp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   saturated;

    modport source (
        output valid, point_x, point_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, saturated,
        output ready
    );
endinterface

/* rtl/chp_front.sv */
// front pipeline: clamps t, forms t^2, t^3 and the hermite weights
`include "cubic_hermite_point_assert.svh"

module chp_front (
    input  logic            clk,
    input  logic            rst_n,
    chp_item_if.sink        item,
    input  chp_pkg::qstat_t qstat,
    output logic            push,
    output chp_pkg::job_t   push_data
);
    import chp_pkg::*;

    logic    v1_reg, v2_reg, v3_reg;
    coords_t c1_reg, c2_reg, c3_reg;
    tparam_t t1_reg, t2_reg, t3_reg;
    tsq_t    tt_reg;
    tparam_t sq_reg;
    tsq_t    sqt_reg;

    tparam_t t_clamp;
    tsq_t    tt_round;
    tparam_t sq_next;
    tsq_t    cube_round;
    tparam_t cube;
    weight_t w_t, w_t2, w_t3;
    qlevel_t inflight;
    logic    accept;

    // credit check: front stages plus queue entries never exceed the queue
    assign inflight   = qlevel_t'(v1_reg) + qlevel_t'(v2_reg) + qlevel_t'(v3_reg)
                      + qstat.level;
    assign item.ready = (inflight < qlevel_t'(Q_DEPTH));
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (item.interp_param[PARAM_WIDTH-1])
        begin
            t_clamp = '0;
        end
        else if (item.interp_param[PARAM_WIDTH-2:0] > T_ONE)
        begin
            t_clamp = T_ONE;
        end
        else
        begin
            t_clamp = item.interp_param[PARAM_WIDTH-2:0];
        end
    end

    assign tt_round   = tt_reg + T_HALF;
    assign sq_next    = tt_round[PARAM_FRAC +: T_W];
    assign cube_round = sqt_reg + T_HALF;
    assign cube       = cube_round[PARAM_FRAC +: T_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg <= '{item.start_x, item.start_y, item.start_tan_x, item.start_tan_y,
                    item.end_x, item.end_y, item.end_tan_x, item.end_tan_y};
        t1_reg <= t_clamp;

        c2_reg <= c1_reg;
        t2_reg <= t1_reg;
        tt_reg <= tsq_t'(t1_reg) * tsq_t'(t1_reg);

        c3_reg  <= c2_reg;
        t3_reg  <= t2_reg;
        sq_reg  <= sq_next;
        sqt_reg <= tsq_t'(sq_next) * tsq_t'(t2_reg);
    end

    assign w_t  = to_weight(t3_reg);
    assign w_t2 = to_weight(sq_reg);
    assign w_t3 = to_weight(cube);

    assign push        = v3_reg;
    assign push_data.c = c3_reg;
    assign push_data.h1 = (w_t3 <<< 1) - w_t2 - (w_t2 <<< 1) + WEIGHT_ONE;
    assign push_data.h2 = w_t2 + (w_t2 <<< 1) - (w_t3 <<< 1);
    assign push_data.h3 = w_t3 - (w_t2 <<< 1) + w_t;
    assign push_data.h4 = w_t3 - w_t2;

    `CHP_ASSERT_IMP(a_front_clamp, v1_reg, t1_reg <= T_ONE, "t left the unit range")
    `CHP_ASSERT_IMP(a_front_partition, push,
        (push_data.h1 + push_data.h2) == WEIGHT_ONE, "point weights do not sum to one")

endmodule

/* rtl/chp_queue.sv */
// job queue between the front and the back
`include "cubic_hermite_point_assert.svh"

module chp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  chp_pkg::job_t    push_data,
    input  logic             pop,
    output chp_pkg::job_t    pop_data,
    output chp_pkg::qstat_t  qstat
);
    import chp_pkg::*;

    job_t    mem_reg [Q_DEPTH];
    qptr_t   wr_ptr_reg, rd_ptr_reg;
    qlevel_t level_reg, level_next;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = mem_reg[rd_ptr_reg];
    assign qstat.level = level_reg;
    assign qstat.empty = (level_reg == '0);

    `CHP_ASSERT_IMP(a_queue_no_overflow, push && !pop,
        level_reg != qlevel_t'(Q_DEPTH), "push into a full queue")
    `CHP_ASSERT_NXT(a_queue_level, push && !pop,
        level_reg == $past(level_reg) + 1'b1, "queue level missed a push")

endmodule

/* rtl/chp_back.sv */
// back pipeline: weighted sums per axis, rounding, saturation, result register
`include "cubic_hermite_point_assert.svh"

module chp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  chp_pkg::qstat_t qstat,
    input  chp_pkg::job_t   job,
    output logic            pop,
    chp_result_if.source    result
);
    import chp_pkg::*;

    logic   v1_reg, v2_reg, ov_reg;
    logic   rdy1, rdy2, rdy3;
    prod_t  px_reg [4];
    prod_t  py_reg [4];
    sum_t   sax_reg, sbx_reg, say_reg, sby_reg;
    sum_t   sx, sy;
    res_t   rx, ry;
    coord_t point_x_reg, point_y_reg;
    logic   sat_reg;
    logic   ovf_x, ovf_y;

    function automatic logic overflows(input res_t r);
        return !((&r[RES_W-1:COORD_WIDTH-1]) || !(|r[RES_W-1:COORD_WIDTH-1]));
    endfunction

    function automatic coord_t clip(input res_t r);
        if (overflows(r))
        begin
            return r[RES_W-1] ? COORD_MIN : COORD_MAX;
        end
        return r[COORD_WIDTH-1:0];
    endfunction

    assign rdy3 = !ov_reg || result.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pop  = !qstat.empty && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= !qstat.empty;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                ov_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            px_reg[0] <= prod_t'(job.c.start_x)     * prod_t'(job.h1);
            px_reg[1] <= prod_t'(job.c.end_x)       * prod_t'(job.h2);
            px_reg[2] <= prod_t'(job.c.start_tan_x) * prod_t'(job.h3);
            px_reg[3] <= prod_t'(job.c.end_tan_x)   * prod_t'(job.h4);
            py_reg[0] <= prod_t'(job.c.start_y)     * prod_t'(job.h1);
            py_reg[1] <= prod_t'(job.c.end_y)       * prod_t'(job.h2);
            py_reg[2] <= prod_t'(job.c.start_tan_y) * prod_t'(job.h3);
            py_reg[3] <= prod_t'(job.c.end_tan_y)   * prod_t'(job.h4);
        end
        if (v1_reg && rdy2)
        begin
            sax_reg <= sum_t'(px_reg[0]) + sum_t'(px_reg[1]);
            sbx_reg <= sum_t'(px_reg[2]) + sum_t'(px_reg[3]) + SUM_HALF;
            say_reg <= sum_t'(py_reg[0]) + sum_t'(py_reg[1]);
            sby_reg <= sum_t'(py_reg[2]) + sum_t'(py_reg[3]) + SUM_HALF;
        end
        if (v2_reg && rdy3)
        begin
            point_x_reg <= clip(rx);
            point_y_reg <= clip(ry);
            sat_reg     <= ovf_x || ovf_y;
        end
    end

    // the half-lsb bias sits in one pair sum, so the shift rounds half up
    assign sx    = sax_reg + sbx_reg;
    assign sy    = say_reg + sby_reg;
    assign rx    = sx[SUM_W-1:PARAM_FRAC];
    assign ry    = sy[SUM_W-1:PARAM_FRAC];
    assign ovf_x = overflows(rx);
    assign ovf_y = overflows(ry);

    assign result.valid     = ov_reg;
    assign result.point_x   = point_x_reg;
    assign result.point_y   = point_y_reg;
    assign result.saturated = sat_reg;

    `CHP_ASSERT_IMP(a_back_sat_at_limit, result.valid && result.saturated,
        result.point_x == COORD_MAX || result.point_x == COORD_MIN ||
        result.point_y == COORD_MAX || result.point_y == COORD_MIN,
        "saturated flag without a clipped coordinate")

endmodule

/* rtl/cubic_hermite_point.sv */
// top level of the 2d cubic hermite curve point evaluator
//
//  channel   dir  handshake      payload
//  item      in   valid/ready    start_x start_y start_tan_x start_tan_y
//                                end_x end_y end_tan_x end_tan_y interp_param
//  result    out  valid/ready    point_x point_y saturated
//
//  one transaction per cycle in both directions while result ready is held
//  with the result side ready a transaction passes three front stages, the
//  queue write, the product stage, the pair-sum stage and the result register
//  rst_n clears only control state (stage valids, queue pointers and level)
//  the front never stalls: it takes a transaction while front stages plus
//  queue entries stay below the 8-entry queue depth
//  the back stalls stage by stage on result ready, draining the queue
module cubic_hermite_point (
    input  logic         clk,
    input  logic         rst_n,
    chp_item_if.sink     item,
    chp_result_if.source result
);
    import chp_pkg::*;

    // front to queue
    logic   push;
    job_t   push_data;

    // queue to back
    logic   pop;
    job_t   pop_data;
    qstat_t qstat;

    // front: clamp t, square and cube it, then form the four basis weights
    chp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // queue decouples the fixed-latency front from the stallable back
    chp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // back: eight products, weighted sums per axis, round and saturate
    chp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .job    (pop_data),
        .pop    (pop),
        .result (result)
    );

endmodule

/* tb/hermite_point_check.sv */
// monitor that predicts each hermite curve point and compares it with the result channel
module hermite_point_check (
    input  logic  clk,
    input  logic  rst_n,
    chp_item_if   item,
    chp_result_if result,
    output int    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import chp_pkg::*;

    localparam longint W_ONE  = longint'(1) <<< PARAM_FRAC;
    localparam longint W_HALF = longint'(1) <<< (PARAM_FRAC - 1);

    typedef struct {
        coord_t x;
        coord_t y;
        logic   clipped;
    } curve_point_t;

    curve_point_t pending_points[$];

    initial fail_count = 0;

    // round the axis sum back to the coordinate format, then clip to range
    function automatic coord_t round_clip(input longint acc, inout logic clipped);
        longint r;
        r = (acc + W_HALF) >>> PARAM_FRAC;
        if (r > longint'(COORD_MAX))
        begin
            clipped = 1'b1;
            return COORD_MAX;
        end
        if (r < longint'(COORD_MIN))
        begin
            clipped = 1'b1;
            return COORD_MIN;
        end
        return coord_t'(r);
    endfunction

    function automatic curve_point_t hermite_point(input coords_t c, input param_t tp);
        longint t, t2, t3, h1, h2, h3, h4, sx, sy;
        curve_point_t p;
        t = longint'($signed(tp));
        if (t < 0)
            t = 0;
        if (t > W_ONE)
            t = W_ONE;
        t2 = (t * t + W_HALF) >>> PARAM_FRAC;
        t3 = (t2 * t + W_HALF) >>> PARAM_FRAC;
        h1 = 2 * t3 - 3 * t2 + W_ONE;
        h2 = 3 * t2 - 2 * t3;
        h3 = t3 - 2 * t2 + t;
        h4 = t3 - t2;
        sx = longint'($signed(c.start_x)) * h1 + longint'($signed(c.end_x)) * h2
           + longint'($signed(c.start_tan_x)) * h3 + longint'($signed(c.end_tan_x)) * h4;
        sy = longint'($signed(c.start_y)) * h1 + longint'($signed(c.end_y)) * h2
           + longint'($signed(c.start_tan_y)) * h3 + longint'($signed(c.end_tan_y)) * h4;
        p.clipped = 1'b0;
        p.x = round_clip(sx, p.clipped);
        p.y = round_clip(sy, p.clipped);
        return p;
    endfunction

    always @(posedge clk)
    begin : watch
        coords_t      c;
        curve_point_t want;
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                c.start_x     = item.start_x;
                c.start_y     = item.start_y;
                c.start_tan_x = item.start_tan_x;
                c.start_tan_y = item.start_tan_y;
                c.end_x       = item.end_x;
                c.end_y       = item.end_y;
                c.end_tan_x   = item.end_tan_x;
                c.end_tan_y   = item.end_tan_y;
                pending_points.push_back(hermite_point(c, item.interp_param));
            end
            if (result.valid && result.ready)
            begin
                if (pending_points.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: x %0d y %0d sat %0b",
                             $time, result.point_x, result.point_y, result.saturated);
                    fail_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (result.point_x !== want.x || result.point_y !== want.y
                        || result.saturated !== want.clipped)
                    begin
                        $display("%0t: expected x %0d y %0d sat %0b, actual x %0d y %0d sat %0b",
                                 $time, want.x, want.y, want.clipped,
                                 result.point_x, result.point_y, result.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/cubic_hermite_point_tb.sv */
// stimulus and verdict for the cubic hermite curve point evaluator
module cubic_hermite_point_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chp_pkg::*;

    // CYCLE_LIMIT sits well above the slowest correct run
    localparam int RANDOM_POINTS = 650;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AT       = 150;    // result count at which the long stall starts
    localparam int HOLD_CYCLES   = 90;     // long enough to fill the internal queue
    localparam int SETTLE_CYCLES = 20;     // idle time after the final drain, before the verdict

    logic clk;
    logic rst_n;
    int   fail_count;
    int   sent_count;
    int   rx_count;
    bit   burst;        // sender offers back to back
    bit   hold_active;  // receiver is in its long stall

    chp_item_if   item_ch();
    chp_result_if result_ch();

    cubic_hermite_point DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predicts every accepted item and scores the results
    hermite_point_check point_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs or loses a transaction
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one item transaction: optional idle gap, then hold valid until ready
    task automatic offer(input coords_t c, input param_t tp);
        int gap;
        gap = (burst || hold_active) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.start_x      <= c.start_x;
        item_ch.start_y      <= c.start_y;
        item_ch.start_tan_x  <= c.start_tan_x;
        item_ch.start_tan_y  <= c.start_tan_y;
        item_ch.end_x        <= c.end_x;
        item_ch.end_y        <= c.end_y;
        item_ch.end_tan_x    <= c.end_tan_x;
        item_ch.end_tan_y    <= c.end_tan_y;
        item_ch.interp_param <= tp;
        item_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sent_count++;
    endtask

    // stop offering until every result in flight has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sent_count != rx_count);
    endtask

    // mix of full-range, near-zero and extreme coordinates
    function automatic coord_t rand_coord();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return coord_t'($urandom);
        if (pick < 17)
            return coord_t'(int'($urandom_range(0, 131072)) - 65536);
        case (pick)
            17:      return COORD_MAX;
            18:      return COORD_MIN;
            default: return coord_t'(-1);
        endcase
    endfunction

    function automatic coords_t rand_coords();
        coords_t c;
        c.start_x     = rand_coord();
        c.start_y     = rand_coord();
        c.start_tan_x = rand_coord();
        c.start_tan_y = rand_coord();
        c.end_x       = rand_coord();
        c.end_y       = rand_coord();
        c.end_tan_x   = rand_coord();
        c.end_tan_y   = rand_coord();
        return c;
    endfunction

    // mostly inside [0,1], with the clamp edges and out-of-range values too
    function automatic param_t rand_param();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return param_t'($urandom_range(0, 65536));
        if (pick < 8)
            return param_t'($urandom);
        if (pick == 8)
            return '0;
        return param_t'(T_ONE);
    endfunction

    // result side: random stalls, quiet stretches, and one long hold-off
    initial
    begin : result_side
        int stall;
        bit quiet;
        quiet = 1'b0;
        rx_count = 0;
        hold_active = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_count % 60 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (rx_count == HOLD_AT)
            begin
                // sender goes back to back meanwhile, so the input has to stall
                hold_active = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            rx_count++;
        end
    end

    // item side and verdict
    initial
    begin : item_side
        coords_t gen;   // a plain segment used by the clamp checks
        coords_t c;
        sent_count = 0;
        burst = 1'b0;
        rst_n <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.start_x      <= '0;
        item_ch.start_y      <= '0;
        item_ch.start_tan_x  <= '0;
        item_ch.start_tan_y  <= '0;
        item_ch.end_x        <= '0;
        item_ch.end_y        <= '0;
        item_ch.end_tan_x    <= '0;
        item_ch.end_tan_y    <= '0;
        item_ch.interp_param <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gen = coords_t'{coord_t'(300000), coord_t'(-150000), coord_t'(40960),
                        coord_t'(-81920), coord_t'(-500000), coord_t'(700000),
                        coord_t'(12288), coord_t'(4096)};

        // all zero
        offer('0, '0);
        // t at zero, just above, half, just below one, one
        offer(gen, '0);
        offer(gen, param_t'(1));
        offer(gen, param_t'(32768));
        offer(gen, param_t'(65535));
        offer(gen, param_t'(T_ONE));
        // negative t clamps to the start point
        offer(gen, param_t'(-1));
        offer(gen, param_t'(-131072));
        // t above one clamps to the end point
        offer(gen, param_t'(65537));
        offer(gen, param_t'(131071));
        // tangents push both axes past the top, then past the bottom
        offer(coords_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN}, param_t'(32768));
        offer(coords_t'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX}, param_t'(32768));
        // only x clips
        offer(coords_t'{COORD_MAX, coord_t'(0), COORD_MAX, coord_t'(0),
                        COORD_MAX, coord_t'(0), COORD_MIN, coord_t'(0)}, param_t'(32768));
        // only y clips, downward
        offer(coords_t'{coord_t'(0), COORD_MIN, coord_t'(0), COORD_MIN,
                        coord_t'(0), COORD_MIN, coord_t'(0), COORD_MAX}, param_t'(21845));
        // extremes everywhere, tangents of the same sign as the points
        offer(coords_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, param_t'(16384));
        offer(coords_t'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}, param_t'(49152));
        // tangents only, near the start tangent weight peak
        offer(coords_t'{coord_t'(0), coord_t'(0), COORD_MAX, COORD_MIN,
                        coord_t'(0), coord_t'(0), COORD_MIN, COORD_MAX}, param_t'(21845));
        // smallest magnitudes, where rounding dominates
        offer(coords_t'{8{coord_t'(-1)}}, param_t'(21845));
        offer(coords_t'{8{coord_t'(1)}}, param_t'(43691));
        offer(coords_t'{8{coord_t'(1)}}, param_t'(1));

        drain();

        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_POINTS / 2)
                drain();
            c = rand_coords();
            offer(c, rand_param());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/chp_pkg.sv
rtl/chp_if.sv
rtl/chp_front.sv
rtl/chp_queue.sv
rtl/chp_back.sv
rtl/cubic_hermite_point.sv
tb/hermite_point_check.sv
tb/cubic_hermite_point_tb.sv
